### rtl/core/avg_pkg.sv
// ============================================================================
// Arc vertex generator package
// Shared widths, register codes, CORDIC tables and pipeline types.
// ============================================================================
`default_nettype none

package avg_pkg;

    // Field widths.
    localparam int VERTEX_W   = 12;
    localparam int RADIUS_W   = 16;
    localparam int ANGLE_W    = 17;
    localparam int SEG_W      = 12;
    localparam int COORD_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARC_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS  = 2'd2;

    // Register reset values and the lower segment bound.
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
    localparam logic [ANGLE_W-1:0]  ANGLE_RESET  = 17'd65536;
    localparam logic [SEG_W-1:0]    MIN_SEGMENTS = 12'd6;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Phase division: dividend is (index * angle) << FRAC_BITS.
    localparam int PROD_W    = VERTEX_W + ANGLE_W;
    localparam int FRAC_BITS = 16;
    localparam int REM_W     = SEG_W;
    localparam int DIV_STEPS = PROD_W + FRAC_BITS - REM_W;
    localparam int PHASE_W   = 32;

    // CORDIC datapath.
    localparam int START_W = 30;
    localparam int DP_W    = 34;
    localparam int GAIN_W  = 30;
    localparam int START_PROD_W = RADIUS_W + GAIN_W;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [DP_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [DP_W-1:0] HALF_TURN    = 34'sd2147483648;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W       = 32;
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Output rounding to Q8.8 and saturation bounds.
    localparam int ROUND_SHIFT = 14;
    localparam logic signed [DP_W-1:0] ROUND_HALF = 34'sd8192;
    localparam logic signed [DP_W-1:0] COORD_MAX  = 34'sd65535;
    localparam logic signed [DP_W-1:0] COORD_MIN  = -34'sd65536;

    // Classification flags that travel with an item.
    typedef struct packed {
        logic last;
        logic oor;
    } tag_t;

    // Classified item held in the queue.
    typedef struct packed {
        logic [VERTEX_W-1:0] index;
        tag_t                tag;
    } item_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [ANGLE_W-1:0] arc_angle;
        logic [SEG_W-1:0]   seg_count;
        logic [START_W-1:0] start_x;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/core/avg_front.sv
// ============================================================================
// Arc vertex generator front end
// Holds the configuration registers, accepts vertex indexes and classifies
// them against the segment count before they enter the queue.
// ============================================================================
`default_nettype none

module avg_front
    import avg_pkg::*;
#(
    parameter int MAX_SEGMENTS     = 4095,
    parameter int DEFAULT_SEGMENTS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VERTEX_W-1:0]   vertex_index,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       item_valid,
    input  wire logic                  item_ready,
    output item_t                      item,
    output cfg_t                       cfg
);

    logic [RADIUS_W-1:0]     radius_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic [SEG_W-1:0]        seg_reg;
    logic [SEG_W-1:0]        seg_clamped;
    logic [START_W-1:0]      start_x_reg;
    logic [START_PROD_W-1:0] start_prod;
    logic                    item_valid_reg;
    item_t                   item_reg;
    logic                    accept;

    // Writes always taken; user keeps the block idle when they arrive, unchecked.
    assign cfg_ready = 1'b1;

    // Segment count is clamped into its legal range on write.
    always_comb
    begin
        seg_clamped = cfg_data[SEG_W-1:0];
        if (seg_clamped < MIN_SEGMENTS)
        begin
            seg_clamped = MIN_SEGMENTS;
        end
        if (int'(seg_clamped) > MAX_SEGMENTS)
        begin
            seg_clamped = SEG_W'(MAX_SEGMENTS);
        end
    end

    // Configuration registers; zero radius and zero angle writes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            angle_reg  <= ANGLE_RESET;
            seg_reg    <= SEG_W'(DEFAULT_SEGMENTS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS:
                begin
                    if (cfg_data[RADIUS_W-1:0] != '0)
                    begin
                        radius_reg <= cfg_data[RADIUS_W-1:0];
                    end
                end
                CFG_ARC_ANGLE:
                begin
                    if (cfg_data[ANGLE_W-1:0] != '0)
                    begin
                        angle_reg <= cfg_data[ANGLE_W-1:0];
                    end
                end
                CFG_SEGMENTS:
                begin
                    seg_reg <= seg_clamped;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Gain-scaled start vector, refreshed from the radius every cycle.
    assign start_prod = START_PROD_W'(radius_reg) * START_PROD_W'(GAIN_Q30);

    always_ff @(posedge clk)
    begin
        start_x_reg <= start_prod[START_PROD_W-1 -: START_W];
    end

    // Input register: accept when empty or when the queue takes the current word.
    assign in_ready = !item_valid_reg || item_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Classify the index against the end of the arc.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.index    <= vertex_index;
            item_reg.tag.last <= (vertex_index == seg_reg);
            item_reg.tag.oor  <= (vertex_index > seg_reg);
        end
    end

    assign item_valid    = item_valid_reg;
    assign item          = item_reg;
    assign cfg.arc_angle = angle_reg;
    assign cfg.seg_count = seg_reg;
    assign cfg.start_x   = start_x_reg;

endmodule

`default_nettype wire

### rtl/core/avg_fifo.sv
// ============================================================================
// Arc vertex generator queue
// Small first-in first-out buffer of classified items between front and back.
// ============================================================================
`default_nettype none

module avg_fifo
    import avg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire item_t push_item,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output item_t     pop_item
);

    item_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/avg_phase_div.sv
// ============================================================================
// Arc vertex generator phase divider
// Multiplies the index by the arc angle, then divides by the segment count
// one quotient bit per stage to form a 32-bit phase.
// ============================================================================
`default_nettype none

module avg_phase_div
    import avg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire item_t               in_item,
    input  wire cfg_t                cfg,
    output logic                     out_valid,
    output logic [PHASE_W-1:0]       out_phase,
    output tag_t                     out_tag
);

    logic                mul_vld_reg;
    logic [PROD_W-1:0]   prod_reg;
    tag_t                mul_tag_reg;
    logic [DIV_STEPS-1:0] vld_reg;
    logic [REM_W-1:0]    rem_reg  [DIV_STEPS];
    logic [PHASE_W-1:0]  quo_reg  [DIV_STEPS];
    logic [PROD_W-1:0]   prod_s_reg [DIV_STEPS];
    tag_t                tag_reg  [DIV_STEPS];

    // Multiply stage: index times arc angle.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= PROD_W'(in_item.index) * PROD_W'(cfg.arc_angle);
            mul_tag_reg <= in_item.tag;
        end
    end

    // Valid bits move with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            vld_reg     <= '0;
        end
        else if (adv)
        begin
            mul_vld_reg <= in_valid;
            vld_reg     <= {vld_reg[DIV_STEPS-2:0], mul_vld_reg};
        end
    end

    // Restoring division; the quotient's upper bits are zero for in-range
    // indexes, so the remainder starts from the top of the product.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        localparam int BIT = DIV_STEPS - 1 - j;
        logic [REM_W-1:0]   rem_in;
        logic [PHASE_W-1:0] quo_in;
        logic [PROD_W-1:0]  prod_in;
        tag_t               tag_in;
        logic               dbit;
        logic [REM_W:0]     trial;
        logic [REM_W:0]     diff;

        if (j == 0)
        begin : g_first
            assign rem_in  = prod_reg[PROD_W-1 -: REM_W];
            assign quo_in  = '0;
            assign prod_in = prod_reg;
            assign tag_in  = mul_tag_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign prod_in = prod_s_reg[j-1];
            assign tag_in  = tag_reg[j-1];
        end

        if (BIT >= FRAC_BITS)
        begin : g_dbit
            assign dbit = prod_in[BIT-FRAC_BITS];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        assign trial = {rem_in, dbit};
        assign diff  = trial - {1'b0, cfg.seg_count};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (trial >= {1'b0, cfg.seg_count})
                begin
                    rem_reg[j] <= diff[REM_W-1:0];
                    quo_reg[j] <= {quo_in[PHASE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= trial[REM_W-1:0];
                    quo_reg[j] <= {quo_in[PHASE_W-2:0], 1'b0};
                end
                prod_s_reg[j] <= prod_in;
                tag_reg[j]    <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_phase = quo_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/core/avg_cordic.sv
// ============================================================================
// Arc vertex generator CORDIC
// Folds the phase into the right half plane and rotates the gain-scaled
// radius vector, one micro-rotation per stage.
// ============================================================================
`default_nettype none

module avg_cordic
    import avg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire logic [PHASE_W-1:0]     in_phase,
    input  wire tag_t                   in_tag,
    input  wire logic [START_W-1:0]     start_x,
    output logic                        out_valid,
    output logic signed [DP_W-1:0]      out_x,
    output logic signed [DP_W-1:0]      out_y,
    output tag_t                        out_tag
);

    logic signed [DP_W-1:0] z_ext;
    logic signed [DP_W-1:0] x_start;
    logic signed [DP_W-1:0] fold_x;
    logic signed [DP_W-1:0] fold_z;
    logic signed [DP_W-1:0] f_x_reg;
    logic signed [DP_W-1:0] f_z_reg;
    tag_t                   f_tag_reg;
    logic [CORDIC_STAGES:0] vld_reg;
    logic signed [DP_W-1:0] x_reg [CORDIC_STAGES];
    logic signed [DP_W-1:0] y_reg [CORDIC_STAGES];
    logic signed [DP_W-1:0] z_reg [CORDIC_STAGES];
    tag_t                   tag_reg [CORDIC_STAGES];

    // Fold the phase into one half turn and flip the start vector to match.
    assign z_ext   = {{(DP_W-PHASE_W){in_phase[PHASE_W-1]}}, in_phase};
    assign x_start = {{(DP_W-START_W){1'b0}}, start_x};

    always_comb
    begin
        fold_x = x_start;
        fold_z = z_ext;
        if (z_ext > QUARTER_TURN)
        begin
            fold_z = z_ext - HALF_TURN;
            fold_x = -x_start;
        end
        else if (z_ext < -QUARTER_TURN)
        begin
            fold_z = z_ext + HALF_TURN;
            fold_x = -x_start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_x_reg   <= fold_x;
            f_z_reg   <= fold_z;
            f_tag_reg <= in_tag;
        end
    end

    // Valid bits move with the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CORDIC_STAGES-1:0], in_valid};
        end
    end

    // Micro-rotations; arithmetic shifts round toward minus infinity.
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_stage
        logic signed [DP_W-1:0] x_in;
        logic signed [DP_W-1:0] y_in;
        logic signed [DP_W-1:0] z_in;
        tag_t                   tag_in;
        logic signed [DP_W-1:0] angle;

        if (k == 0)
        begin : g_first
            assign x_in   = f_x_reg;
            assign y_in   = '0;
            assign z_in   = f_z_reg;
            assign tag_in = f_tag_reg;
        end
        else
        begin : g_next
            assign x_in   = x_reg[k-1];
            assign y_in   = y_reg[k-1];
            assign z_in   = z_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign angle = signed'({{(DP_W-ATAN_W){1'b0}}, ATAN_TAB[k]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_in[DP_W-1])
                begin
                    x_reg[k] <= x_in - (y_in >>> k);
                    y_reg[k] <= y_in + (x_in >>> k);
                    z_reg[k] <= z_in - angle;
                end
                else
                begin
                    x_reg[k] <= x_in + (y_in >>> k);
                    y_reg[k] <= y_in - (x_in >>> k);
                    z_reg[k] <= z_in + angle;
                end
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STAGES];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];
    assign out_tag   = tag_reg[CORDIC_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/arc_vertex_generator.sv
// ============================================================================
// Arc vertex generator
// Streams the vertices of a circular arc around the origin, one per index.
// ============================================================================
// Usage:
// Configuration words (radius, arc_angle, segment_count) arrive on the cfg
// channel, which is always ready; write them only while no vertex is pending.
// Each input word carries a vertex index i; each output word carries the
// point r*cos(i*A/n), r*sin(i*A/n) in signed Q8.8 with a last-vertex flag,
// or zero coordinates with out_of_range set when i exceeds n.
// A vertex passes the front register, queue, multiply stage, 33-step phase
// divider, CORDIC fold register and stages, and output register. Throughput
// is one vertex per cycle without stalls; both pipelines are fully staged.
// A four-word queue separates the classifying front from the arithmetic back.
// When the receiver stalls, the back pipeline and the output register hold;
// the front keeps accepting until the queue fills, then in_ready drops.
// Reset empties all pipeline stages and the queue and restores radius 1.0,
// a full-turn arc angle and DEFAULT_SEGMENTS segments.
// ============================================================================
`default_nettype none

module arc_vertex_generator
    import avg_pkg::*;
#(
    parameter int MAX_SEGMENTS     = 4095,
    parameter int DEFAULT_SEGMENTS = 32,
    parameter int CORDIC_STAGES    = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VERTEX_W-1:0]   vertex_index,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [COORD_W-1:0]  x_coord,
    output logic signed [COORD_W-1:0]  y_coord,
    output logic                       last_vertex,
    output logic                       out_of_range,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic                     front_valid;
    logic                     front_ready;
    item_t                    front_item;
    cfg_t                     cfg;
    logic                     q_valid;
    item_t                    q_item;
    logic                     adv;
    logic                     div_valid;
    logic [PHASE_W-1:0]       div_phase;
    tag_t                     div_tag;
    logic                     rot_valid;
    logic signed [DP_W-1:0]   rot_x;
    logic signed [DP_W-1:0]   rot_y;
    tag_t                     rot_tag;
    logic                     out_valid_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic                     last_reg;
    logic                     oor_reg;

    // Round half up to Q8.8 and saturate to the coordinate range.
    function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [DP_W-1:0] v);
        logic signed [DP_W-1:0] q;
        q = (v + ROUND_HALF) >>> ROUND_SHIFT;
        if (q > COORD_MAX)
        begin
            q = COORD_MAX;
        end
        else if (q < COORD_MIN)
        begin
            q = COORD_MIN;
        end
        return q[COORD_W-1:0];
    endfunction

    avg_front #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .DEFAULT_SEGMENTS (DEFAULT_SEGMENTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (front_valid),
        .item_ready   (front_ready),
        .item         (front_item),
        .cfg          (cfg)
    );

    avg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (adv),
        .pop_item   (q_item)
    );

    // The back pipeline moves whenever the output register can take a word.
    assign adv = !out_valid_reg || out_ready;

    avg_phase_div u_phase_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .cfg       (cfg),
        .out_valid (div_valid),
        .out_phase (div_phase),
        .out_tag   (div_tag)
    );

    avg_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_phase  (div_phase),
        .in_tag    (div_tag),
        .start_x   (cfg.start_x),
        .out_valid (rot_valid),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_tag   (rot_tag)
    );

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rot_valid;
        end
    end

    // Output register payload; past-the-end indexes give zero coordinates.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (rot_tag.oor)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else
            begin
                x_reg <= to_coord(rot_x);
                y_reg <= to_coord(rot_y);
            end
            last_reg <= rot_tag.last;
            oor_reg  <= rot_tag.oor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_coord      = x_reg;
    assign y_coord      = y_reg;
    assign last_vertex  = last_reg;
    assign out_of_range = oor_reg;

endmodule

`default_nettype wire

### rtl/core/avg_checker.sv
// ============================================================================
// Arc vertex generator checker
// Port-level properties of the result stream, bound to the top level.
// ============================================================================
`default_nettype none

module avg_checker
    import avg_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic signed [COORD_W-1:0] x_coord,
    input wire logic signed [COORD_W-1:0] y_coord,
    input wire logic                  last_vertex,
    input wire logic                  out_of_range,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord)
            && $stable(last_vertex) && $stable(out_of_range))
        else $error("result word changed while stalled");

    // An index cannot be both the end of the arc and past it.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(last_vertex && out_of_range))
        else $error("last_vertex and out_of_range both set");

    // Past-the-end results carry zero coordinates.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> (x_coord == '0) && (y_coord == '0))
        else $error("out-of-range result has nonzero coordinates");

    // The configuration channel never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind arc_vertex_generator avg_checker u_avg_checker (.*);

`default_nettype wire
